### sv/lfps_pkg.sv
// lfps_pkg: shared types, widths, register indexes and reset values for the
// line follower steering core. Used by every module of the block.
`timescale 1ns / 1ps
package lfps_pkg;

	// widths of the item fields
	localparam int SUM_WIDTH   = 16;
	localparam int SEEN_W      = 5;
	localparam int SPEED_W     = 8;
	localparam int ERR_W       = 3;
	localparam int CASE_W      = 2;
	localparam int GAIN_W      = 12;
	localparam int DERIV_W     = 4;
	localparam int PD_W        = 18;
	localparam int TOT_W       = SUM_WIDTH + 14;
	localparam int CORR_W      = TOT_W - 4;
	localparam int SPD_W       = SUM_WIDTH + 12;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_BOOST = 3'd5;

	// register reset values
	localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 12'd400;
	localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 12'd0;
	localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 12'd240;
	localparam logic [SPEED_W-1:0] RST_BASE_SPEED = 8'd95;
	localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 8'd80;
	localparam logic [SPEED_W-1:0] RST_TURN_BOOST = 8'd60;

	// drive case codes
	typedef enum logic [CASE_W-1:0] {
		CASE_PID   = 2'd0,
		CASE_LEFT  = 2'd1,
		CASE_RIGHT = 2'd2,
		CASE_LOST  = 2'd3
	} drive_case_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SPD
	} state_t;

	// tuning registers as seen by the datapath
	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SPEED_W-1:0] base_speed;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] turn_boost;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### sv/line_follow_pid_steer_core.sv
// Line follower steering controller: five sensor bits in, two motor speeds out.
// Controller is lfps_ctrl, datapath lfps_dp, registers lfps_cfg (lfps_pkg).
//
// Channels: s_* carries one item per control tick with line_seen in
// s_tdata[4:0]. m_* returns one result item per input item: left and right
// speeds and the steering error in m_tdata, the drive case in m_tuser.
// cfg_* writes one tuning register per handshake (index 0..5: gain_p, gain_i,
// gain_d, base_speed, min_speed, turn_boost); cfg_ready is always high and
// writes are expected only while no tick is in flight.
// Steps: the accepting edge loads the error, then integral multiply,
// correction sum, and speed mix into the output register.
// Flow: the four-step sequencer takes a new item only when back in idle,
// so s_tready is high only while the sequencer is idle.
// The output register lets the next item be accepted while a result waits.
// If m_tready stays low the sequencer holds in its last step and the input
// side stalls once the next result is ready.
// Reset (arst_n low) restores register defaults and clears the integral,
// the previous error and all valid flags.
`timescale 1ns / 1ps
module line_follow_pid_steer_core import lfps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [4:0] line_seen
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] left_speed, [15:8] right_speed,
	                                          // [18:16] steer_error
	output logic [CASE_W-1:0]      m_tuser,   // [1:0] drive_case
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                    cfg;
	cmd_t                    cmd;
	status_t                 status;
	logic [SPEED_W-1:0]      left_speed, right_speed;
	logic [CASE_W-1:0]       drive_case;
	logic signed [ERR_W-1:0] steer_error;

	lfps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lfps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.line_seen   (s_tdata[SEEN_W-1:0]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.drive_case  (drive_case),
		.steer_error (steer_error)
	);

	// pack result fields, upper bits zero
	assign m_tdata = {{(OUT_TDATA_W - 2*SPEED_W - ERR_W){1'b0}},
	                  steer_error, right_speed, left_speed};
	assign m_tuser = drive_case;

endmodule

### sv/lfps_cfg.sv
// lfps_cfg: tuning register file written over the configuration channel.
// Depends on lfps_pkg for register indexes and reset values.
`timescale 1ns / 1ps
module lfps_cfg import lfps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= RST_GAIN_P;
			cfg_q.gain_i     <= RST_GAIN_I;
			cfg_q.gain_d     <= RST_GAIN_D;
			cfg_q.base_speed <= RST_BASE_SPEED;
			cfg_q.min_speed  <= RST_MIN_SPEED;
			cfg_q.turn_boost <= RST_TURN_BOOST;
		end else if (wr) begin
			unique case (cfg_index)
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				REG_BASE_SPEED: cfg_q.base_speed <= cfg_data[SPEED_W-1:0];
				REG_MIN_SPEED:  cfg_q.min_speed  <= cfg_data[SPEED_W-1:0];
				REG_TURN_BOOST: cfg_q.turn_boost <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### sv/lfps_ctrl.sv
// lfps_ctrl: sequencer for one control tick (load, multiply, add, speeds).
// Depends on lfps_pkg for the state, command and status types.
`timescale 1ns / 1ps
module lfps_ctrl import lfps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_SPD;
			ST_SPD:  if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_SPD:  cmd.emit = status.out_free;
			default: ;
		endcase
	end

endmodule

### sv/lfps_dp.sv
// lfps_dp: error decode, integral and derivative state, PID products,
// speed mixing and clamping, and the output register.
// Depends on lfps_pkg; driven by lfps_ctrl commands.
`timescale 1ns / 1ps
module lfps_dp import lfps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [SEEN_W-1:0]      line_seen,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SPEED_W-1:0]     left_speed,
	output logic [SPEED_W-1:0]     right_speed,
	output logic [CASE_W-1:0]      drive_case,
	output logic signed [ERR_W-1:0] steer_error
);

	// state and step registers
	logic signed [ERR_W-1:0]     last_err_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [DERIV_W-1:0]   deriv_q;
	drive_case_t                 case_q;
	logic signed [TOT_W-1:0]     prod_i_q;
	logic signed [PD_W-1:0]      pd_q;
	logic signed [CORR_W-1:0]    corr_q;
	logic                        out_valid_q;
	logic [SPEED_W-1:0]          left_q, right_q;
	logic [CASE_W-1:0]           case_out_q;
	logic signed [ERR_W-1:0]     err_out_q;

	logic signed [ERR_W-1:0]     err_d;
	drive_case_t                 case_d;
	logic                        pid_d;
	logic signed [DERIV_W-1:0]   deriv_d;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_d;
	logic signed [SUM_WIDTH+12:0] prod_i_d;
	logic signed [PD_W-1:0]      gp_x, gd_x, pe_d, de_d;
	logic signed [TOT_W-1:0]     total_d, total_adj;
	logic signed [SPD_W-1:0]     base_x, boost_x, corr_x, ls_d, rs_d;
	logic [SPEED_W-1:0]          left_d, right_d;

	// clamp a mixed speed to min_speed..255
	function automatic logic [SPEED_W-1:0] clamp_speed(
		input logic signed [SPD_W-1:0] v,
		input logic [SPEED_W-1:0]      lo
	);
		logic [SPEED_W-1:0] r;
		if (v > SPD_W'($signed({1'b0, SPEED_MAX}))) begin
			r = SPEED_MAX;
		end else if (v < SPD_W'($signed({1'b0, lo}))) begin
			r = lo;
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

	// error decode: only the three inner sensors reach the pid path
	always_comb begin
		err_d  = '0;
		case_d = CASE_PID;
		pid_d  = 1'b1;
		if (line_seen[0]) begin
			case_d = CASE_LEFT;
			pid_d  = 1'b0;
		end else if (line_seen[SEEN_W-1]) begin
			case_d = CASE_RIGHT;
			pid_d  = 1'b0;
		end else begin
			case (line_seen[3:1])
				3'b000: begin
					case_d = CASE_LOST;
					err_d  = (last_err_q > 3'sd0) ? -3'sd2 : 3'sd2;
				end
				3'b001:  err_d = 3'sd1;
				3'b100:  err_d = -3'sd1;
				default: err_d = 3'sd0;
			endcase
		end
	end

	// saturating integral and derivative
	always_comb begin
		sum_ext = {sum_q[SUM_WIDTH-1], sum_q} + (SUM_WIDTH+1)'(err_d);
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_d = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
			                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_d = sum_ext[SUM_WIDTH-1:0];
		end
		deriv_d = DERIV_W'(err_d) - DERIV_W'(last_err_q);
	end

	// load step: state update only on pid ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			sum_q      <= '0;
		end else if (cmd.load && pid_d) begin
			last_err_q <= err_d;
			sum_q      <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q   <= err_d;
			deriv_q <= deriv_d;
			case_q  <= case_d;
		end
	end

	// products: one wide multiply for the integral term
	always_comb begin
		prod_i_d = $signed({1'b0, cfg.gain_i}) * sum_q;
		gp_x     = $signed(PD_W'(cfg.gain_p));
		gd_x     = $signed(PD_W'(cfg.gain_d));
		pe_d     = gp_x * PD_W'(err_q);
		de_d     = gd_x * PD_W'(deriv_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_i_q <= TOT_W'(prod_i_d);
			pd_q     <= pe_d + de_d;
		end
	end

	// sum and divide by 16 truncating toward zero
	always_comb begin
		total_d   = prod_i_q + TOT_W'(pd_q);
		total_adj = total_d + (total_d[TOT_W-1] ? TOT_W'(15) : TOT_W'(0));
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			corr_q <= total_adj[TOT_W-1:4];
		end
	end

	// speed mixing, turn boost and clamp
	always_comb begin
		base_x  = SPD_W'($signed({1'b0, cfg.base_speed}));
		boost_x = SPD_W'($signed({1'b0, cfg.turn_boost}));
		corr_x  = SPD_W'(corr_q);
		ls_d    = base_x - corr_x;
		rs_d    = base_x + corr_x;
		if (err_q == -3'sd2) begin
			ls_d = ls_d - boost_x;
			rs_d = rs_d + boost_x;
		end else if (err_q == 3'sd2) begin
			ls_d = ls_d + boost_x;
			rs_d = rs_d - boost_x;
		end
		case (case_q)
			CASE_LEFT: begin
				left_d  = cfg.min_speed;
				right_d = SPEED_MAX;
			end
			CASE_RIGHT: begin
				left_d  = SPEED_MAX;
				right_d = cfg.min_speed;
			end
			default: begin
				left_d  = clamp_speed(ls_d, cfg.min_speed);
				right_d = clamp_speed(rs_d, cfg.min_speed);
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_q     <= left_d;
			right_q    <= right_d;
			case_out_q <= case_q;
			err_out_q  <= err_q;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign left_speed      = left_q;
	assign right_speed     = right_q;
	assign drive_case      = case_out_q;
	assign steer_error     = err_out_q;

	// checks
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result not presented after emit");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> $stable(sum_q))
		else $error("integral changed outside a load");

	a_sharp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (line_seen[0] || line_seen[SEEN_W-1])) |=>
		($stable(last_err_q) && $stable(sum_q)))
		else $error("sharp turn changed pid state");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_err_q != 3'sd3) && (last_err_q != -3'sd3) && (last_err_q != -3'sd4))
		else $error("last error out of range");

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for line_follow_pid_steer_core, with a PID steering predictor,
// directed probes and paced random ticks under several tunings.
// Depends on lfps_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb;
	import lfps_pkg::*;

	// unused register slots, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int     SETTLE_CYCLES = 8;
	localparam int     PHASES        = 8;
	localparam int     PHASE_ITEMS   = 112;
	localparam longint LIMIT_NS      = 64'd2_000_000;
	localparam int     PROBE_N       = 24;

	// one result item as the core emits it
	typedef struct packed {
		logic [SPEED_W-1:0]      left;
		logic [SPEED_W-1:0]      right;
		drive_case_t             dcase;
		logic signed [ERR_W-1:0] err;
	} steer_res_t;

	// directed probe: sensor pattern, and its result where it is typed in
	typedef struct packed {
		logic [SEEN_W-1:0] seen;
		logic              typed;
		steer_res_t        res;
	} probe_t;

	// right after reset with default tuning; a lost line there gives error +2:
	// correction (400*2 + 240*2)/16 = 80, boost 60 -> left 95-80+60 = 75 -> 80, right 115
	localparam probe_t PROBES [PROBE_N] = '{
		'{5'b00001, 1'b1, '{RST_MIN_SPEED, SPEED_MAX, CASE_LEFT, 3'sd0}},
		'{5'b10000, 1'b1, '{SPEED_MAX, RST_MIN_SPEED, CASE_RIGHT, 3'sd0}},
		'{5'b10001, 1'b1, '{RST_MIN_SPEED, SPEED_MAX, CASE_LEFT, 3'sd0}},
		'{5'b11111, 1'b1, '{RST_MIN_SPEED, SPEED_MAX, CASE_LEFT, 3'sd0}},
		'{5'b00000, 1'b1, '{RST_MIN_SPEED, 8'd115, CASE_LOST, 3'sd2}},
		'{5'b00000, 1'b0, '0},
		'{5'b00000, 1'b0, '0},
		'{5'b00100, 1'b0, '0},
		'{5'b00010, 1'b0, '0},
		'{5'b01000, 1'b0, '0},
		'{5'b00110, 1'b0, '0},
		'{5'b01100, 1'b0, '0},
		'{5'b01110, 1'b0, '0},
		'{5'b01010, 1'b0, '0},
		'{5'b00010, 1'b0, '0},
		'{5'b00000, 1'b0, '0},
		'{5'b01000, 1'b0, '0},
		'{5'b00000, 1'b0, '0},
		'{5'b00001, 1'b0, '0},
		'{5'b00000, 1'b0, '0},
		'{5'b10000, 1'b0, '0},
		'{5'b11110, 1'b0, '0},
		'{5'b01111, 1'b0, '0},
		'{5'b01110, 1'b0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [CASE_W-1:0]      m_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor copy of tuning and controller state
	logic [GAIN_W-1:0]  k_p, k_i, k_d;
	logic [SPEED_W-1:0] base_spd, min_spd, boost;
	int                 prev_err;
	longint             err_integral;

	steer_res_t steer_queue[$];
	int         bad_results = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;

	line_follow_pid_steer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("FAIL line_follow_pid_steer_core");
		$finish;
	end

	function automatic logic [SPEED_W-1:0] clamp_speed(input longint v);
		if (v > longint'(SPEED_MAX)) v = longint'(SPEED_MAX);
		if (v < longint'(min_spd)) v = longint'(min_spd);
		return v[SPEED_W-1:0];
	endfunction

	// next steering result for one tick, advances integral and previous error
	function automatic steer_res_t steer_predict(input logic [SEEN_W-1:0] seen);
		steer_res_t r;
		int         pos;
		int         cnt;
		int         e;
		longint     lim;
		longint     total;
		longint     corr;
		longint     ls;
		longint     rs;
		lim = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
		pos = 0;
		cnt = 0;
		r.err = '0;
		// outer sensors force a sharp turn, left one wins
		if (seen[0]) begin
			r.left = clamp_speed(0);
			r.right = SPEED_MAX;
			r.dcase = CASE_LEFT;
			return r;
		end
		if (seen[SEEN_W-1]) begin
			r.left = SPEED_MAX;
			r.right = clamp_speed(0);
			r.dcase = CASE_RIGHT;
			return r;
		end
		// mean position of seen sensors, weights -2..2
		for (int i = 0; i < SEEN_W; i++) begin
			if (seen[i]) begin
				pos += i - 2;
				cnt++;
			end
		end
		if (cnt == 0) begin
			pos = (prev_err > 0) ? 2 : -2;
			r.dcase = CASE_LOST;
		end else begin
			pos = pos / cnt;
			r.dcase = CASE_PID;
		end
		e = -pos;
		// saturating integral
		err_integral += e;
		if (err_integral > lim) err_integral = lim;
		if (err_integral < -lim - 1) err_integral = -lim - 1;
		total = longint'(k_p) * e + longint'(k_i) * err_integral
			+ longint'(k_d) * (e - prev_err);
		corr = total / 16;
		prev_err = e;
		ls = longint'(base_spd) - corr;
		rs = longint'(base_spd) + corr;
		if (e > 1) begin
			ls += longint'(boost);
			rs -= longint'(boost);
		end else if (e < -1) begin
			ls -= longint'(boost);
			rs += longint'(boost);
		end
		r.left = clamp_speed(ls);
		r.right = clamp_speed(rs);
		r.err = e[ERR_W-1:0];
		return r;
	endfunction

	function automatic logic [SEEN_W-1:0] pick_seen();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) return '0;
		if (roll < 75) return {1'b0, 3'($urandom_range(7)), 1'b0};
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		if ($urandom_range(1) == 0) return 12'($urandom_range(127));
		return 12'($urandom_range(4095));
	endfunction

	task automatic report_bad(input string why, input steer_res_t want, input steer_res_t got);
		bad_results++;
		if (bad_results <= 10)
			$display("%s: want L%0d R%0d case %0d err %0d, got L%0d R%0d case %0d err %0d",
				why, want.left, want.right, want.dcase, want.err,
				got.left, got.right, got.dcase, got.err);
	endtask

	// one tick item, with optional idle cycles ahead of it
	task automatic send_seen(input logic [SEEN_W-1:0] seen, input logic typed,
		input steer_res_t typed_res);
		steer_res_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W-SEEN_W){1'b0}}, seen};
		do @(posedge clk); while (!s_tready);
		pred = steer_predict(seen);
		steer_queue.push_back(typed ? typed_res : pred);
	endtask

	// stop sending and wait for every pending result, then let the core settle
	task automatic wait_results_done();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (steer_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_P:     k_p = val;
			REG_GAIN_I:     k_i = val;
			REG_GAIN_D:     k_d = val;
			REG_BASE_SPEED: base_spd = val[SPEED_W-1:0];
			REG_MIN_SPEED:  min_spd = val[SPEED_W-1:0];
			REG_TURN_BOOST: boost = val[SPEED_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all six registers; byte-wide ones get junk in the upper bits
	task automatic load_tuning(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
		input logic [GAIN_W-1:0] gd, input logic [SPEED_W-1:0] base,
		input logic [SPEED_W-1:0] minv, input logic [SPEED_W-1:0] bst);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_BASE_SPEED, {4'($urandom_range(15)), base});
		write_reg(REG_MIN_SPEED, {4'($urandom_range(15)), minv});
		write_reg(REG_TURN_BOOST, {4'($urandom_range(15)), bst});
	endtask

	// random ticks, with runs of one pattern to wind up the integral
	task automatic run_random(input int n);
		int                sent;
		int                reps;
		logic [SEEN_W-1:0] seen;
		sent = 0;
		while (sent < n) begin
			seen = pick_seen();
			reps = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : 1;
			repeat (reps) send_seen(seen, 1'b0, '0);
			sent += reps;
			if ($urandom_range(49) == 0) wait_results_done();
		end
	endtask

	// receiver side pacing
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		steer_res_t got;
		steer_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.left = m_tdata[7:0];
			got.right = m_tdata[15:8];
			got.err = m_tdata[18:16];
			got.dcase = drive_case_t'(m_tuser);
			if (steer_queue.size() == 0) begin
				report_bad("unexpected item", '0, got);
			end else begin
				want = steer_queue.pop_front();
				if (got.left !== want.left || got.right !== want.right
					|| got.dcase !== want.dcase || got.err !== want.err)
					report_bad("mismatch", want, got);
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		k_p = RST_GAIN_P;
		k_i = RST_GAIN_I;
		k_d = RST_GAIN_D;
		base_spd = RST_BASE_SPEED;
		min_spd = RST_MIN_SPEED;
		boost = RST_TURN_BOOST;
		prev_err = 0;
		err_integral = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed probes on reset tuning
		for (int i = 0; i < PROBE_N; i++)
			send_seen(PROBES[i].seen, PROBES[i].typed, PROBES[i].res);
		wait_results_done();

		// writes to unused slots are dropped
		write_reg(REG_SPARE_6, 12'($urandom_range(4095)));
		write_reg(REG_SPARE_7, 12'($urandom_range(4095)));

		// random phases: extremes of tuning first, then random tuning
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase
			if (ph == 0)
				load_tuning(12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'h00, 8'hFF);
			else if (ph == 1)
				load_tuning(12'h000, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00);
			else if (ph == 2)
				load_tuning(pick_gain(), pick_gain(), pick_gain(), 8'($urandom_range(255)),
					8'hFF, 8'($urandom_range(255)));
			else
				load_tuning(pick_gain(), pick_gain(), pick_gain(), 8'($urandom_range(255)),
					8'($urandom_range(120)), 8'($urandom_range(255)));
			run_random(PHASE_ITEMS);
			wait_results_done();
		end

		if (bad_results == 0 && steer_queue.size() == 0)
			$display("PASS line_follow_pid_steer_core");
		else
			$display("FAIL line_follow_pid_steer_core");
		$finish;
	end

endmodule
